FILE: hw/rtl/lxt_pkg.sv
// ----------------------------------------------------------------------------
// lxt_pkg
// Token kinds, error codes, keyword table and the token/bundle types shared
// by the scanner front end, the token queue and the token drain.
// ----------------------------------------------------------------------------
`default_nettype none

package lxt_pkg;

    // token kinds
    localparam logic [5:0] K_LEFT_PAREN    = 6'd0;
    localparam logic [5:0] K_RIGHT_PAREN   = 6'd1;
    localparam logic [5:0] K_LEFT_BRACE    = 6'd2;
    localparam logic [5:0] K_RIGHT_BRACE   = 6'd3;
    localparam logic [5:0] K_COMMA         = 6'd4;
    localparam logic [5:0] K_DOT           = 6'd5;
    localparam logic [5:0] K_MINUS         = 6'd6;
    localparam logic [5:0] K_PLUS          = 6'd7;
    localparam logic [5:0] K_SEMICOLON     = 6'd8;
    localparam logic [5:0] K_SLASH         = 6'd9;
    localparam logic [5:0] K_STAR          = 6'd10;
    localparam logic [5:0] K_BANG          = 6'd11;
    localparam logic [5:0] K_EQUAL         = 6'd13;
    localparam logic [5:0] K_GREATER       = 6'd15;
    localparam logic [5:0] K_LESS          = 6'd17;
    localparam logic [5:0] K_NEW_LINE      = 6'd19;
    localparam logic [5:0] K_STRING        = 6'd20;
    localparam logic [5:0] K_NUMBER        = 6'd21;
    localparam logic [5:0] K_IDENTIFIER    = 6'd22;
    localparam logic [5:0] K_KEY0          = 6'd23;
    localparam logic [5:0] K_END           = 6'd39;
    localparam logic [5:0] K_ERROR         = 6'd0;

    // error codes
    localparam logic [1:0] E_NONE          = 2'd0;
    localparam logic [1:0] E_UNEXPECTED    = 2'd1;
    localparam logic [1:0] E_UNTERMINATED  = 2'd2;

    // most tokens one byte can produce
    localparam int unsigned MAX_TOKENS     = 4;
    localparam int unsigned NUM_KEYWORDS   = 16;

    // keyword text, right justified: char 0 is the most significant used byte
    localparam logic [47:0] KW_TEXT [NUM_KEYWORDS] = '{
        48'("and"),   48'("class"), 48'("else"),   48'("false"),
        48'("fun"),   48'("for"),   48'("if"),     48'("nil"),
        48'("or"),    48'("print"), 48'("return"), 48'("super"),
        48'("this"),  48'("true"),  48'("var"),    48'("while")
    };
    localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
        3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
        3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
        logic [1:0]  err;
    } t_token;

    // all tokens caused by one source byte, in order
    typedef struct packed {
        logic [2:0]                  cnt;
        t_token [MAX_TOKENS-1:0]     tok;
    } t_bundle;

endpackage

`default_nettype wire

FILE: hw/rtl/lxt_byte_if.sv
// ----------------------------------------------------------------------------
// lxt_byte_if
// Source byte channel: one source byte and its final-byte flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lxt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_source;

    modport source (output valid, output source_byte, output end_of_source, input ready);
    modport sink   (input valid, input source_byte, input end_of_source, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lxt_token_if.sv
// ----------------------------------------------------------------------------
// lxt_token_if
// Token channel: one token per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lxt_token_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic [1:0]  error_code;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output line_number, output error_code,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input line_number, input error_code,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lxt_cfg_if.sv
// ----------------------------------------------------------------------------
// lxt_cfg_if
// Configuration write channel: first line number, one write per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lxt_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] first_line_number;

    modport source (output valid, output first_line_number, input ready);
    modport sink   (input valid, input first_line_number, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lxt_front.sv
// ----------------------------------------------------------------------------
// lxt_front
// Scanner front end: classifies each source byte against the open token,
// updates scan state and builds the bundle of tokens the byte completes.
// ----------------------------------------------------------------------------
`default_nettype none

module lxt_front
    import lxt_pkg::*;
#(
    parameter int unsigned OFFSET_BITS     = 16,
    parameter int unsigned KEYWORD_MAX_LEN = 6
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lxt_byte_if.sink   i_src,
    lxt_cfg_if.sink    i_cfg,
    input  wire logic  i_full,
    output logic       o_push,
    output t_bundle    o_bundle
);

    localparam int unsigned FW = $clog2(KEYWORD_MAX_LEN + 1);
    localparam int unsigned IW = $clog2(KEYWORD_MAX_LEN);
    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [FW-1:0] FILL_MAX = FW'(KEYWORD_MAX_LEN);

    typedef enum logic [3:0] {
        M_IDLE, M_OPER, M_SLASH, M_COMMENT, M_STRING,
        M_INT, M_DOTWAIT, M_FRAC, M_WORD
    } t_mode;

    typedef logic [OFFSET_BITS:0] t_pos;

    // scan state
    t_mode                   r_mode, mode_a, mode_b, n_mode;
    logic [OFFSET_BITS-1:0]  r_pos, pos_n, n_pos;
    logic [OFFSET_BITS-1:0]  r_ostart, ostart_b, n_ostart;
    logic [15:0]             r_line, line_a, line_b, n_line;
    logic [15:0]             r_first;
    logic [5:0]              r_pend, pend_b, n_pend;
    logic [7:0]              r_buf [KEYWORD_MAX_LEN];
    logic [7:0]              n_buf [KEYWORD_MAX_LEN];
    logic [FW-1:0]           r_fill, fill_a, fill_b, n_fill;
    logic                    r_tlong, tlong_a, tlong_b, n_tlong;

    logic [7:0]  c;
    logic        accept, consumed;
    logic        cfg_load;
    logic        is_dig, is_alp, is_quote;
    t_pos        pos_x, pos1, dot_a, end_x, dot_f, ost_x, ostb_x;
    logic [5:0]  kw_old, kw_new;
    logic [5:0][7:0] w_old, w_new;

    // token slots in emit order: continue x2, start, flush x2, end
    logic   [5:0] sv;
    t_token       st [6];
    t_bundle      bun;
    logic   [2:0] cnt;

    // ---- helpers ----
    function automatic logic [15:0] sat16(input t_pos v);
        logic [32:0] w;
        w = 33'(v);
        return (w > 33'd65535) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic t_token mk(input logic [5:0] kind, input t_pos s, input t_pos e,
                                  input logic [15:0] line, input logic [1:0] err);
        t_token t;
        t.kind   = kind;
        t.start  = sat16(s);
        t.length = (e >= s) ? sat16(e - s) : 16'd0;
        t.line   = line;
        t.err    = err;
        return t;
    endfunction

    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [5:0] kw_kind(input logic [5:0][7:0] w,
                                           input logic [FW-1:0] fill, input logic tl);
        logic [5:0] kind;
        logic       same;
        kind = K_IDENTIFIER;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            same = (32'(fill) == 32'(KW_LEN[k])) && !tl;
            for (int i = 0; i < 6; i++) begin
                if (i < int'(KW_LEN[k]) &&
                    w[i] != KW_TEXT[k][8*(int'(KW_LEN[k])-1-i) +: 8]) begin
                    same = 1'b0;
                end
            end
            if (same) kind = K_KEY0 + 6'(k);
        end
        return kind;
    endfunction

    assign i_src.ready = !i_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_src.valid && !i_full;
    assign c           = i_src.source_byte;

    // a write reloads the line counter when the next byte starts a new source
    assign cfg_load = i_cfg.valid &&
                      (accept ? i_src.end_of_source : (r_pos == '0 && r_mode == M_IDLE));

    // character classes
    assign is_dig   = (c >= "0") && (c <= "9");
    assign is_alp   = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    assign is_quote = (c == 8'h22) || (c == 8'h27);

    // keyword lookup before and after this byte
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_old[i] = r_buf[i];
            w_new[i] = n_buf[i];
        end
    end
    assign kw_old = kw_kind(w_old, r_fill, r_tlong);
    assign kw_new = kw_kind(w_new, fill_b, tlong_b);

    // ---- scan one byte ----
    always_comb begin
        pos_x  = {1'b0, r_pos};
        pos1   = pos_x + t_pos'(1);
        dot_a  = (r_pos != '0) ? pos_x - t_pos'(1) : '0;
        ost_x  = {1'b0, r_ostart};
        pos_n  = (r_pos == POS_MAX) ? r_pos : r_pos + OFFSET_BITS'(1);
        end_x  = {1'b0, pos_n};
        dot_f  = end_x - t_pos'(1);

        sv = '0;
        for (int i = 0; i < 6; i++) st[i] = '0;

        n_buf   = r_buf;
        mode_a  = r_mode;
        line_a  = r_line;
        fill_a  = r_fill;
        tlong_a = r_tlong;
        consumed = 1'b0;

        // continue the open token
        unique case (r_mode)
            M_OPER: begin
                mode_a = M_IDLE;
                sv[0]  = 1'b1;
                if (c == "=") begin
                    consumed = 1'b1;
                    st[0] = mk(r_pend + 6'd1, ost_x, pos1, r_line, E_NONE);
                end else begin
                    st[0] = mk(r_pend, ost_x, pos_x, r_line, E_NONE);
                end
            end
            M_SLASH: begin
                if (c == "/") begin
                    mode_a = M_COMMENT;
                    consumed = 1'b1;
                end else begin
                    mode_a = M_IDLE;
                    sv[0] = 1'b1;
                    st[0] = mk(K_SLASH, ost_x, pos_x, r_line, E_NONE);
                end
            end
            M_COMMENT: begin
                if (c == 8'h0A) mode_a = M_IDLE;
                else            consumed = 1'b1;
            end
            M_STRING: begin
                consumed = 1'b1;
                if (is_quote) begin
                    mode_a = M_IDLE;
                    sv[0] = 1'b1;
                    st[0] = mk(K_STRING, ost_x, pos1, r_line, E_NONE);
                end else if (c == 8'h0A) begin
                    line_a = inc16(r_line);
                end
            end
            M_INT: begin
                if (is_dig) begin
                    consumed = 1'b1;
                end else if (c == ".") begin
                    mode_a = M_DOTWAIT;
                    consumed = 1'b1;
                end else begin
                    mode_a = M_IDLE;
                    sv[0] = 1'b1;
                    st[0] = mk(K_NUMBER, ost_x, pos_x, r_line, E_NONE);
                end
            end
            M_DOTWAIT: begin
                if (is_dig) begin
                    mode_a = M_FRAC;
                    consumed = 1'b1;
                end else begin
                    mode_a = M_IDLE;
                    sv[1:0] = 2'b11;
                    st[0] = mk(K_NUMBER, ost_x, dot_a, r_line, E_NONE);
                    st[1] = mk(K_DOT, dot_a, dot_a + t_pos'(1), r_line, E_NONE);
                end
            end
            M_FRAC: begin
                if (is_dig) begin
                    consumed = 1'b1;
                end else begin
                    mode_a = M_IDLE;
                    sv[0] = 1'b1;
                    st[0] = mk(K_NUMBER, ost_x, pos_x, r_line, E_NONE);
                end
            end
            M_WORD: begin
                if (is_alp || is_dig) begin
                    consumed = 1'b1;
                    if (r_fill < FILL_MAX) begin
                        n_buf[r_fill[IW-1:0]] = c;
                        fill_a = r_fill + FW'(1);
                    end else begin
                        tlong_a = 1'b1;
                    end
                end else begin
                    mode_a = M_IDLE;
                    sv[0] = 1'b1;
                    st[0] = mk(kw_old, ost_x, pos_x, r_line, E_NONE);
                end
            end
            default: begin
                mode_a = M_IDLE;
            end
        endcase

        // start a new token
        mode_b   = mode_a;
        ostart_b = r_ostart;
        pend_b   = r_pend;
        line_b   = line_a;
        fill_b   = fill_a;
        tlong_b  = tlong_a;
        if (!consumed) begin
            priority case (c)
                "(":     begin sv[2] = 1'b1; st[2] = mk(K_LEFT_PAREN, pos_x, pos1, r_line, E_NONE); end
                ")":     begin sv[2] = 1'b1; st[2] = mk(K_RIGHT_PAREN, pos_x, pos1, r_line, E_NONE); end
                "{":     begin sv[2] = 1'b1; st[2] = mk(K_LEFT_BRACE, pos_x, pos1, r_line, E_NONE); end
                "}":     begin sv[2] = 1'b1; st[2] = mk(K_RIGHT_BRACE, pos_x, pos1, r_line, E_NONE); end
                ",":     begin sv[2] = 1'b1; st[2] = mk(K_COMMA, pos_x, pos1, r_line, E_NONE); end
                ".":     begin sv[2] = 1'b1; st[2] = mk(K_DOT, pos_x, pos1, r_line, E_NONE); end
                "-":     begin sv[2] = 1'b1; st[2] = mk(K_MINUS, pos_x, pos1, r_line, E_NONE); end
                "+":     begin sv[2] = 1'b1; st[2] = mk(K_PLUS, pos_x, pos1, r_line, E_NONE); end
                ";":     begin sv[2] = 1'b1; st[2] = mk(K_SEMICOLON, pos_x, pos1, r_line, E_NONE); end
                "*":     begin sv[2] = 1'b1; st[2] = mk(K_STAR, pos_x, pos1, r_line, E_NONE); end
                default: begin
                    ostart_b = r_pos;
                    if (c == "!" || c == "=" || c == "<" || c == ">") begin
                        mode_b = M_OPER;
                        pend_b = (c == "!") ? K_BANG : (c == "=") ? K_EQUAL :
                                 (c == ">") ? K_GREATER : K_LESS;
                    end else if (c == " " || c == 8'h0D || c == 8'h09) begin
                        mode_b = mode_a;
                    end else if (c == 8'h0A) begin
                        sv[2]  = 1'b1;
                        st[2]  = mk(K_NEW_LINE, pos_x, pos1, r_line, E_NONE);
                        line_b = inc16(line_a);
                    end else if (c == "/") begin
                        mode_b = M_SLASH;
                    end else if (is_quote) begin
                        mode_b = M_STRING;
                    end else if (is_dig) begin
                        mode_b = M_INT;
                    end else if (is_alp) begin
                        mode_b   = M_WORD;
                        n_buf[0] = c;
                        fill_b   = FW'(1);
                        tlong_b  = 1'b0;
                    end else begin
                        sv[2] = 1'b1;
                        st[2] = mk(K_ERROR, pos_x, pos1, r_line, E_UNEXPECTED);
                    end
                end
            endcase
        end

        // flush at the final byte, then the end token
        ostb_x = {1'b0, ostart_b};
        if (i_src.end_of_source) begin
            sv[5] = 1'b1;
            st[5] = mk(K_END, end_x, end_x, line_b, E_NONE);
            unique case (mode_b)
                M_OPER:  begin sv[3] = 1'b1; st[3] = mk(pend_b, ostb_x, end_x, line_b, E_NONE); end
                M_SLASH: begin sv[3] = 1'b1; st[3] = mk(K_SLASH, ostb_x, end_x, line_b, E_NONE); end
                M_STRING: begin
                    sv[3] = 1'b1;
                    st[3] = mk(K_ERROR, ostb_x, end_x, line_b, E_UNTERMINATED);
                end
                M_INT, M_FRAC: begin
                    sv[3] = 1'b1;
                    st[3] = mk(K_NUMBER, ostb_x, end_x, line_b, E_NONE);
                end
                M_DOTWAIT: begin
                    sv[4:3] = 2'b11;
                    st[3] = mk(K_NUMBER, ostb_x, dot_f, line_b, E_NONE);
                    st[4] = mk(K_DOT, dot_f, end_x, line_b, E_NONE);
                end
                M_WORD:  begin sv[3] = 1'b1; st[3] = mk(kw_new, ostb_x, end_x, line_b, E_NONE); end
                default: begin end
            endcase
        end

        // pack valid slots in order, at most four
        cnt = 3'd0;
        bun = '0;
        for (int i = 0; i < 6; i++) begin
            if (sv[i] && cnt < 3'(MAX_TOKENS)) begin
                bun.tok[cnt[1:0]] = st[i];
                cnt = cnt + 3'd1;
            end
        end
        bun.cnt = cnt;

        // next state
        if (i_src.end_of_source) begin
            n_mode = M_IDLE;  n_pos = '0;  n_ostart = '0;
            n_line = r_first; n_pend = '0; n_fill = '0;  n_tlong = 1'b0;
        end else begin
            n_mode = mode_b;  n_pos = pos_n; n_ostart = ostart_b;
            n_line = line_b;  n_pend = pend_b; n_fill = fill_b; n_tlong = tlong_b;
        end
    end

    assign o_push   = accept && (cnt != 3'd0);
    assign o_bundle = bun;

    // ---- state registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_ostart <= '0;
            r_line   <= 16'd1;
            r_first  <= 16'd1;
            r_pend   <= '0;
            r_fill   <= '0;
            r_tlong  <= 1'b0;
        end else begin
            if (accept) begin
                r_mode   <= n_mode;
                r_pos    <= n_pos;
                r_ostart <= n_ostart;
                r_pend   <= n_pend;
                r_fill   <= n_fill;
                r_tlong  <= n_tlong;
            end
            if (i_cfg.valid) r_first <= i_cfg.first_line_number;
            if (cfg_load)    r_line  <= i_cfg.first_line_number;
            else if (accept) r_line  <= n_line;
        end
    end

    // word buffer, payload only
    always_ff @(posedge i_clk) begin
        if (accept) r_buf <= n_buf;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lxt_queue.sv
// ----------------------------------------------------------------------------
// lxt_queue
// Short bundle queue between the scanner front end and the token drain.
// ----------------------------------------------------------------------------
`default_nettype none

module lxt_queue
    import lxt_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_bundle  i_data,
    input  wire logic     i_pop,
    output logic          o_full,
    output logic          o_valid,
    output t_bundle       o_data
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [AW:0] CNT_FULL = (AW+1)'(DEPTH);

    t_bundle       r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            if (i_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lxt_back.sv
// ----------------------------------------------------------------------------
// lxt_back
// Token drain: holds one bundle and hands its tokens out one beat at a
// time, marking the last token of each bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module lxt_back
    import lxt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_qvalid,
    input  wire t_bundle  i_qdata,
    output logic          o_pop,
    lxt_token_if.source   o_tok
);

    t_bundle    r_bun;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       fire, last;
    t_token     cur;

    assign cur  = r_bun.tok[r_idx];
    assign last = ({1'b0, r_idx} == r_bun.cnt - 3'd1);
    assign fire = r_busy && o_tok.ready;
    assign o_pop = i_qvalid && (!r_busy || (fire && last));

    assign o_tok.valid        = r_busy;
    assign o_tok.token_kind   = cur.kind;
    assign o_tok.token_start  = cur.start;
    assign o_tok.token_length = cur.length;
    assign o_tok.line_number  = cur.line;
    assign o_tok.error_code   = cur.err;
    assign o_tok.last_of_run  = last;

    // drain control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (fire) begin
            if (last) r_busy <= 1'b0;
            else      r_idx  <= r_idx + 2'd1;
        end
    end

    // held bundle
    always_ff @(posedge i_clk) begin
        if (o_pop) r_bun <= i_qdata;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/script_lexer_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// script_lexer_tokenizer_unit
// Streaming lexical scanner: source bytes in, tokens out.
//
//   channel  | dir | payload
//   i_src    | in  | source_byte, end_of_source
//   o_tok    | out | token_kind, token_start, token_length, line_number,
//            |     | error_code, last_of_run
//   i_cfg    | in  | first_line_number
//
// One source byte is taken per cycle while the bundle queue is not full; the
// scan logic finishes a byte in the cycle it is taken. Tokens leave the drain
// at one per cycle while the sink is ready; the bundle queue absorbs bursts.
// Tokens are held in the queue, then in the drain. Reset is synchronous and
// clears all control state; the config channel is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module script_lexer_tokenizer_unit
    import lxt_pkg::*;
#(
    parameter int unsigned OFFSET_BITS     = 16,
    parameter int unsigned KEYWORD_MAX_LEN = 6,
    parameter int unsigned QUEUE_DEPTH     = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lxt_byte_if.sink    i_src,
    lxt_cfg_if.sink     i_cfg,
    lxt_token_if.source o_tok
);

    logic    push, pop, full, qvalid;
    t_bundle push_data, q_data;

    lxt_front #(
        .OFFSET_BITS     (OFFSET_BITS),
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_src    (i_src),
        .i_cfg    (i_cfg),
        .i_full   (full),
        .o_push   (push),
        .o_bundle (push_data)
    );

    lxt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (qvalid),
        .o_data  (q_data)
    );

    lxt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (qvalid),
        .i_qdata  (q_data),
        .o_pop    (pop),
        .o_tok    (o_tok)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/lxt_checker.sv
// ----------------------------------------------------------------------------
// lxt_checker
// Port-level checks on the token channel, bound to the scanner top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lxt_checker
    import lxt_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        tok_valid,
    input wire logic        tok_ready,
    input wire logic [5:0]  tok_kind,
    input wire logic [15:0] tok_start,
    input wire logic [15:0] tok_length,
    input wire logic [1:0]  tok_err,
    input wire logic        tok_last
);

    // stalled token holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(tok_kind) && $stable(tok_start))
        else $error("token changed while stalled");

    // kinds stay in range
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_valid |-> tok_kind <= K_END)
        else $error("token kind out of range");

    // error results carry kind zero
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_valid && tok_err != E_NONE |-> tok_kind == K_ERROR)
        else $error("error token with nonzero kind");

    // end token is empty and closes its run
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_valid && tok_kind == K_END |-> tok_length == 16'd0 && tok_last)
        else $error("bad end token");

endmodule

bind script_lexer_tokenizer_unit lxt_checker u_lxt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .tok_valid  (o_tok.valid),
    .tok_ready  (o_tok.ready),
    .tok_kind   (o_tok.token_kind),
    .tok_start  (o_tok.token_start),
    .tok_length (o_tok.token_length),
    .tok_err    (o_tok.error_code),
    .tok_last   (o_tok.last_of_run)
);

`default_nettype wire
